/* design/mwg_pkg.sv */
// Shared constants, types and the quarter-wave sine ROM for the waveform generator.
// Used by mwg_wave_shaper and multi_waveform_generator_core; no dependencies.

package mwg_pkg;

  // Widths of the phase path, the sine table address and the output sample.
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 8;
  localparam int SAMPLE_BITS     = 16;
  localparam int MAG_BITS        = SAMPLE_BITS - 1;
  localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;

  // Configuration register widths.
  localparam int MODE_BITS  = 2;
  localparam int SCALE_BITS = 15;
  localparam int STEP_BITS  = 31;
  localparam int COUNT_BITS = 16;
  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAVE_MODE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BURST_LENGTH = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [SCALE_BITS-1:0] AMPLITUDE_RESET = 15'd32767;
  localparam logic [STEP_BITS-1:0]  STEP_RESET      = 31'd42852281;
  localparam logic [COUNT_BITS-1:0] BURST_RESET     = 16'd1024;

  // Rounding constant for the Q0.15 amplitude scale.
  localparam int SCALE_FRAC = 15;
  localparam int PROD_BITS  = MAG_BITS + SCALE_BITS + 1;
  localparam logic [PROD_BITS-1:0] SCALE_ROUND = PROD_BITS'(1) << (SCALE_FRAC - 1);

  // Full-scale magnitude, 2^(SAMPLE_BITS-1) - 1.
  localparam logic [MAG_BITS-1:0] FULL_SCALE = {MAG_BITS{1'b1}};

  typedef enum logic [MODE_BITS-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_mode_t;

  // Raw wave value before amplitude scaling, in sign and magnitude form.
  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } raw_sample_t;

  typedef logic [MAG_BITS-1:0] sine_rom_t [TABLE_SIZE];

  // Half of pi in Q30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  // Unsigned long division by shift and subtract, used only to build the table.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One table entry: full scale times the sine at the middle of step k of the quarter
  // period, evaluated with a Q30 Taylor series and rounded half up. Runs only at
  // elaboration.
  function automatic logic [MAG_BITS-1:0] sine_entry(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    logic            negative;
    longint unsigned rounded;
    x        = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (TABLE_ADDR_BITS + 1);
    x2       = (x * x) >> 30;
    term     = x;
    sum      = longint'(x);
    negative = 1'b1;
    for (int n = 1; n < 20; n++) begin
      if (term != 64'd0) begin
        term = div_u64((term * x2) >> 30, 64'(2 * n) * 64'(2 * n + 1));
        sum  = negative ? sum - longint'(term) : sum + longint'(term);
        negative = !negative;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (longint'(Q30_ONE) < sum) begin
      sum = longint'(Q30_ONE);
    end
    rounded = (longint'(sum) * 64'(FULL_SCALE) + (Q30_ONE >> 1)) >> 30;
    return rounded[MAG_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* design/mwg_wave_shaper.sv */
// Maps one phase value to a raw wave sample (sine, square, triangle or sawtooth).
// Pure combinational; depends on mwg_pkg for widths, wave codes and the sine ROM.

module mwg_wave_shaper (
  input  logic [mwg_pkg::PHASE_BITS-1:0] phase,
  input  mwg_pkg::wave_mode_t            wave_mode,
  output mwg_pkg::raw_sample_t           raw
);

  logic [1:0]                             quadrant;
  logic [mwg_pkg::TABLE_ADDR_BITS-1:0]    table_addr;
  logic [mwg_pkg::PHASE_BITS-2:0]         tri_bits;
  logic [mwg_pkg::SAMPLE_BITS-1:0]        ramp_code;
  logic [mwg_pkg::MAG_BITS-1:0]           ramp_low;
  logic [mwg_pkg::MAG_BITS-1:0]           ramp_neg;

  // Quarter-wave addressing: odd quadrants read the table mirrored.
  assign quadrant   = phase[mwg_pkg::PHASE_BITS-1 -: 2];
  assign table_addr = quadrant[0]
                    ? ~phase[mwg_pkg::PHASE_BITS-3 -: mwg_pkg::TABLE_ADDR_BITS]
                    : phase[mwg_pkg::PHASE_BITS-3 -: mwg_pkg::TABLE_ADDR_BITS];

  // Triangle folds the lower phase bits in the second half of the period.
  assign tri_bits = phase[mwg_pkg::PHASE_BITS-1]
                  ? ~phase[mwg_pkg::PHASE_BITS-2:0]
                  : phase[mwg_pkg::PHASE_BITS-2:0];

  // Offset-binary code for the ramp shapes; its MSB set means non-negative.
  always_comb begin
    if (wave_mode == mwg_pkg::WAVE_TRIANGLE) begin
      ramp_code = tri_bits[mwg_pkg::PHASE_BITS-2 -: mwg_pkg::SAMPLE_BITS];
    end else begin
      ramp_code = phase[mwg_pkg::PHASE_BITS-1 -: mwg_pkg::SAMPLE_BITS];
    end
  end

  // Below mid-scale the magnitude is mid minus code; the lowest code clamps to full scale.
  assign ramp_low = ramp_code[mwg_pkg::MAG_BITS-1:0];
  assign ramp_neg = (ramp_low == '0) ? mwg_pkg::FULL_SCALE : (~ramp_low + 1'b1);

  always_comb begin
    case (wave_mode)
      mwg_pkg::WAVE_SINE: begin
        raw.neg = quadrant[1];
        raw.mag = mwg_pkg::SINE_ROM[table_addr];
      end
      mwg_pkg::WAVE_SQUARE: begin
        raw.neg = phase[mwg_pkg::PHASE_BITS-1];
        raw.mag = mwg_pkg::FULL_SCALE;
      end
      mwg_pkg::WAVE_TRIANGLE, mwg_pkg::WAVE_SAWTOOTH: begin
        raw.neg = !ramp_code[mwg_pkg::SAMPLE_BITS-1];
        raw.mag = ramp_code[mwg_pkg::SAMPLE_BITS-1] ? ramp_low : ramp_neg;
      end
      default: begin
        raw.neg = 1'b0;
        raw.mag = '0;
      end
    endcase
  end

endmodule

/* design/multi_waveform_generator_core.sv */
// Top level of the multi-waveform DDS generator: config registers, phase and burst
// state, and a three-register sample pipeline. Depends on mwg_pkg and mwg_wave_shaper.
//
// Channel   Signals                                   Direction  Transaction
// --------  ----------------------------------------  ---------  -------------------------
// input     in_valid, in_ready, restart               in         one sample tick
// output    out_valid, out_ready, sample, last_of_burst out      one scaled sample
// config    cfg_we, cfg_index, cfg_data               in         one register write
//
// One tick is accepted per cycle while the output is not stalled; it passes three registers
// (input register, wave shaping with the sine ROM read, then the amplitude multiplier)
// before its sample is valid.
// The phase accumulator and burst counter update at acceptance, so ticks stream.
// Reset (rst, synchronous) clears phase, counter and valids and loads register defaults;
// in_ready is low while rst is high.
// A stalled output holds each stage that is full; empty stages keep filling.

module multi_waveform_generator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                  last_of_burst,
  input  logic                                  cfg_we,
  input  logic [mwg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mwg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  mwg_pkg::wave_mode_t                    wave_mode;
  logic [mwg_pkg::SCALE_BITS-1:0]         amplitude_scale;
  logic [mwg_pkg::STEP_BITS-1:0]          phase_step;
  logic [mwg_pkg::COUNT_BITS-1:0]         burst_length;

  logic [mwg_pkg::PHASE_BITS-1:0]         phase_accumulator;
  logic [mwg_pkg::COUNT_BITS-1:0]         sample_counter;

  logic [mwg_pkg::PHASE_BITS-1:0]         phase_used;
  logic [mwg_pkg::COUNT_BITS-1:0]         count_used;
  logic                                   burst_end;
  logic                                   in_fire;

  logic                                   s1_valid;
  logic [mwg_pkg::PHASE_BITS-1:0]         s1_phase;
  logic                                   s1_last;
  logic                                   s1_ready;

  mwg_pkg::raw_sample_t                   raw;
  logic                                   s2_valid;
  mwg_pkg::raw_sample_t                   s2_raw;
  logic                                   s2_last;
  logic                                   s2_ready;

  logic                                   out_free;
  logic [mwg_pkg::PROD_BITS-1:0]          product;
  logic [mwg_pkg::SAMPLE_BITS-1:0]        scaled_mag;
  logic [mwg_pkg::SAMPLE_BITS-1:0]        signed_sample;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode       <= mwg_pkg::WAVE_SINE;
      amplitude_scale <= mwg_pkg::AMPLITUDE_RESET;
      phase_step      <= mwg_pkg::STEP_RESET;
      burst_length    <= mwg_pkg::BURST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mwg_pkg::CFG_WAVE_MODE: begin
          wave_mode <= mwg_pkg::wave_mode_t'(cfg_data[mwg_pkg::MODE_BITS-1:0]);
        end
        mwg_pkg::CFG_AMPLITUDE: begin
          amplitude_scale <= cfg_data[mwg_pkg::SCALE_BITS-1:0];
        end
        mwg_pkg::CFG_PHASE_STEP: begin
          phase_step <= cfg_data[mwg_pkg::STEP_BITS-1:0];
        end
        mwg_pkg::CFG_BURST_LENGTH: begin
          burst_length <= cfg_data[mwg_pkg::COUNT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Backpressure: each stage moves when the one after it is empty or moving.
  assign out_free = !out_valid || out_ready;
  assign s2_ready = !s2_valid || out_free;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready && !rst;
  assign in_fire  = in_valid && in_ready;

  // The sample uses the phase before it advances; restart clears first.
  assign phase_used = restart ? '0 : phase_accumulator;
  assign count_used = restart ? '0 : sample_counter;
  assign burst_end  = (count_used == (burst_length - 1'b1));

  // Phase accumulator and burst counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accumulator <= '0;
      sample_counter    <= '0;
    end else if (in_fire) begin
      if (burst_end) begin
        phase_accumulator <= '0;
        sample_counter    <= '0;
      end else begin
        phase_accumulator <= phase_used
                           + mwg_pkg::PHASE_BITS'(phase_step);
        sample_counter    <= count_used + 1'b1;
      end
    end
  end

  // Stage 1: captured phase for this transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_phase <= phase_used;
      s1_last  <= burst_end;
    end
  end

  mwg_wave_shaper u_shaper (
    .phase     (s1_phase),
    .wave_mode (wave_mode),
    .raw       (raw)
  );

  // Stage 2: raw wave value in sign and magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_raw  <= raw;
      s2_last <= s1_last;
    end
  end

  // Amplitude scale with round half up, then the sign goes back on.
  assign product = mwg_pkg::PROD_BITS'(s2_raw.mag) * mwg_pkg::PROD_BITS'(amplitude_scale)
                 + mwg_pkg::SCALE_ROUND;
  assign scaled_mag    = product[mwg_pkg::PROD_BITS-1 -: mwg_pkg::SAMPLE_BITS];
  assign signed_sample = s2_raw.neg ? (~scaled_mag + 1'b1) : scaled_mag;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      sample        <= signed_sample;
      last_of_burst <= s2_last;
    end
  end

endmodule

/* sim/tb_multi_waveform_generator_core.sv */
// Self-checking testbench for multi_waveform_generator_core: directed and random sample
// ticks against a cycle-free model of the phase accumulator, burst counter and wave shaping.
// Depends on mwg_pkg (port widths, register indexes, wave mode enum) and the RTL.
`timescale 1ns / 1ps

module tb_multi_waveform_generator_core;
  import mwg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_DEPTH = 3;
  localparam int TABLE_ENTRIES = 256;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int PEAK = 32767;

  // Expected output of one sample tick.
  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic last_of_burst;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_WAVE_MODE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Model state: registers, phase, burst counter and the quarter-wave table.
  wave_mode_t cur_mode;
  logic [14:0] cur_amp;
  logic [30:0] cur_step;
  logic [15:0] cur_burst;
  logic [31:0] phase_acc;
  logic [15:0] burst_cnt;
  logic [14:0] quarter_wave [TABLE_ENTRIES];

  tick_result_t pending_samples [$];
  int errors = 0;
  int ticks_sent = 0;
  int samples_checked = 0;
  int bursts_ended = 0;
  int reg_writes = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  multi_waveform_generator_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample(sample),
    .last_of_burst(last_of_burst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d samples outstanding.", cycles,
               pending_samples.size());
      $display("** multi_waveform_generator_core: FAILED **");
      $finish;
    end
  end

  // Table entry k: full scale times sin(pi/2 * (k + 0.5) / 256) from a Q30 Taylor series,
  // rounded half up.
  function automatic logic [14:0] sine_mag(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    logic sub;
    x = (PI_HALF_Q30 * longint'(2 * k + 1)) / (64'd2 * TABLE_ENTRIES);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    sub = 1'b1;
    for (int n = 1; n < 20 && term != 0; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc = sub ? acc - longint'(term) : acc + longint'(term);
      sub = !sub;
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(64'd1 << 30)) begin
      acc = longint'(64'd1 << 30);
    end
    return 15'((unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
  endfunction

  // Register values and state right after reset.
  task automatic reset_model();
    cur_mode = WAVE_SINE;
    cur_amp = 15'd32767;
    cur_step = 31'd42852281;
    cur_burst = 16'd1024;
    phase_acc = '0;
    burst_cnt = '0;
  endtask

  // Computes the sample for one tick and advances phase and burst counter.
  function automatic tick_result_t next_sample(input logic clear);
    tick_result_t res;
    logic [31:0] p;
    logic [30:0] fold;
    logic [7:0] addr;
    logic [15:0] end_cnt;
    int r;
    int mag;
    longint unsigned scaled;
    if (clear) begin
      phase_acc = '0;
      burst_cnt = '0;
    end
    p = phase_acc;
    case (cur_mode)
      WAVE_SINE: begin
        // Odd quadrants read the table backward, the second half is negated.
        addr = p[29:22];
        if (p[30]) begin
          addr = ~addr;
        end
        r = p[31] ? -int'(quarter_wave[addr]) : int'(quarter_wave[addr]);
      end
      WAVE_SQUARE: begin
        r = p[31] ? -PEAK : PEAK;
      end
      WAVE_TRIANGLE: begin
        fold = p[31] ? ~p[30:0] : p[30:0];
        r = int'(fold[30:15]) - 32768;
      end
      default: begin
        r = int'(p[31:16]) - 32768;
      end
    endcase
    // The lowest code is clamped to keep the output symmetric.
    if (r < -PEAK) begin
      r = -PEAK;
    end
    mag = (r < 0) ? -r : r;
    scaled = (longint'(mag) * cur_amp + 64'd16384) >> 15;
    res.value = 16'(scaled);
    if (r < 0) begin
      res.value = -res.value;
    end
    end_cnt = cur_burst - 16'd1;
    res.last = (burst_cnt == end_cnt);
    if (res.last) begin
      phase_acc = '0;
      burst_cnt = '0;
    end else begin
      phase_acc = phase_acc + {1'b0, cur_step};
      burst_cnt = burst_cnt + 16'd1;
    end
    return res;
  endfunction

  // Sends one sample tick and records its expected sample once accepted.
  task automatic send_tick(input logic clear);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    restart <= clear;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_samples.push_back(next_sample(clear));
    ticks_sent++;
  endtask

  // Stops sending and lets the pipeline empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_WAVE_MODE: cur_mode = wave_mode_t'(data[1:0]);
      CFG_AMPLITUDE: cur_amp = data[14:0];
      CFG_PHASE_STEP: cur_step = data[30:0];
      default: cur_burst = data[15:0];
    endcase
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // Sample checker with random output stalls.
  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          $error("Unexpected output transaction: sample %0d, last_of_burst %0b",
                 sample, last_of_burst);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (sample !== want.value) begin
            $error("sample: expected %0d, got %0d", want.value, sample);
            errors++;
          end
          if (last_of_burst !== want.last) begin
            $error("last_of_burst: expected %0b, got %0b", want.last, last_of_burst);
            errors++;
          end
          samples_checked++;
          if (want.last) begin
            bursts_ended++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // A few ticks with the register values from reset.
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Every wave at phases zero, just below half and just below a full period; zero phase
  // also hits the clamped lowest code of triangle and sawtooth.
  task automatic test_wave_shapes();
    wave_mode_t modes [4];
    modes = '{WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SAWTOOTH};
    write_reg(CFG_AMPLITUDE, 31'd32767);
    write_reg(CFG_PHASE_STEP, 31'h7FFF_FFFF);
    write_reg(CFG_BURST_LENGTH, 31'd65535);
    foreach (modes[i]) begin
      write_reg(CFG_WAVE_MODE, 31'(modes[i]));
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
    end
  endtask

  // Zero amplitude silences even a full-scale square wave.
  task automatic test_amplitude_zero();
    write_reg(CFG_WAVE_MODE, 31'(WAVE_SQUARE));
    write_reg(CFG_AMPLITUDE, 31'd0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // One-sample bursts, a zero burst length, and a burst length lowered below the count.
  task automatic test_burst_edges();
    write_reg(CFG_WAVE_MODE, 31'(WAVE_SAWTOOTH));
    write_reg(CFG_AMPLITUDE, 31'd20000);
    write_reg(CFG_PHASE_STEP, 31'h0123_4567);
    write_reg(CFG_BURST_LENGTH, 31'd1);
    send_tick(1'b0);
    send_tick(1'b0);
    write_reg(CFG_BURST_LENGTH, 31'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    write_reg(CFG_BURST_LENGTH, 31'd8);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    write_reg(CFG_BURST_LENGTH, 31'd2);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Random settings and ticks under one idling pattern; register writes carry random
  // bits above each register's width.
  task automatic test_random_traffic(input int src_pct, input int sink_pct);
    logic [30:0] junk;
    logic [14:0] amp;
    logic [30:0] step;
    logic [15:0] blen;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (4) begin
      junk = 31'($urandom());
      write_reg(CFG_WAVE_MODE, {junk[30:2], 2'($urandom_range(3))});
      case ($urandom_range(5))
        0: amp = 15'd0;
        1: amp = 15'd32767;
        default: amp = 15'($urandom());
      endcase
      junk = 31'($urandom());
      write_reg(CFG_AMPLITUDE, {junk[30:15], amp});
      case ($urandom_range(4))
        0: step = 31'd0;
        1: step = 31'h7FFF_FFFF;
        2: step = 31'($urandom());
        default: step = 31'($urandom_range(1 << 28, 1 << 22));
      endcase
      write_reg(CFG_PHASE_STEP, step);
      case ($urandom_range(7))
        0: blen = 16'd0;
        1: blen = 16'd65535;
        2: blen = 16'd1;
        default: blen = 16'($urandom_range(40, 2));
      endcase
      junk = 31'($urandom());
      write_reg(CFG_BURST_LENGTH, {junk[30:16], blen});
      repeat (94) send_tick($urandom_range(99) < 3);
    end
  endtask

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      quarter_wave[k] = sine_mag(k);
    end
    reset_model();
    src_idle_pct = 18;
    sink_idle_pct = 70;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_wave_shapes();
    test_amplitude_zero();
    test_burst_edges();
    test_random_traffic(18, 70);
    test_random_traffic(70, 18);
    test_random_traffic(0, 0);

    // Drain and give any stray output time to show up.
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 5) @(posedge clk);

    $display("Checked %0d samples from %0d ticks, %0d burst ends, %0d register writes,",
             samples_checked, ticks_sent, bursts_ended, reg_writes);
    $display("across all four waves with sender and receiver stalls.");
    if (errors == 0) begin
      $display("** multi_waveform_generator_core: PASSED **");
    end else begin
      $display("** multi_waveform_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
